// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for port-level checkers. Clock and reset are
// taken from the names clk and rst in the scope of each use.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

// File: rtl/bam_pkg.sv
// ---------------------------------------------------------------------------
// bam_pkg
// Types and constants shared by the bipartite matcher controller and
// datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package bam_pkg;

  // Storage slots for left rows and right columns
  localparam int HW_SLOTS = 16;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HW_SLOTS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SEARCH,
    ST_UNWIND,
    ST_EMIT
  } state_t;

  // One parent frame of the augmenting-path walk
  typedef struct packed {
    idx_t left;
    cnt_t next;
    idx_t col;
  } frame_t;

  // Controller to datapath
  typedef struct packed {
    logic load_row;
    logic clear_set;
    logic start_aug;
    logic push;
    logic pop;
    logic assign_col;
    logic unwind;
    logic idx_inc;
    logic idx_clear;
    logic emit;
    logic end_set;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cand;
    logic col_free;
    logic sp_zero;
    logic sp_one;
    logic idx_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/bipartite_augmenting_matcher.sv
// ---------------------------------------------------------------------------
// bipartite_augmenting_matcher
// Maximum bipartite matching over a 16 x 16 adjacency matrix by augmenting
// paths, with a stack-based depth-first search.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one adjacency row per word (s_tdata bit j allows
//   right column j); s_tlast closes the set. Rows past the capacity are
//   dropped and flag overflow on every result of that set.
//   Rows load at one per cycle while no set is being searched or emitted.
//   After the closing row, each left row gets one search: a start step,
//   then one push, pop or column assignment per cycle (up to 2 x 15 + 1
//   steps), then the path is written back one stack frame at a time. The
//   search stepper sets the rate, and each row is also loaded and emitted.
//   The m_ channel then gives one word per stored row, in load order, at
//   one per cycle; m_tlast marks the last. While the receiver stalls, the
//   word holds and the rest of the set waits. The next set may load while
//   the final word still waits.
//   Reset (rst, synchronous) empties the row store, frees all columns and
//   drops any pending result.
// ---------------------------------------------------------------------------
`default_nettype none

module bipartite_augmenting_matcher
  import bam_pkg::*;
#(
  parameter int MAX_LEFT  = 16,
  parameter int MAX_RIGHT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] row_bits
  input  wire logic        s_tlast,   // last_row
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [3:0] left_index, [7:4] right_index
  output logic [1:0]       m_tuser,   // [0] matched, [1] overflow
  output logic             m_tlast    // last_result
);

  localparam int LEFT_CAP = (MAX_LEFT  < HW_SLOTS) ? MAX_LEFT  : HW_SLOTS;
  localparam int COL_CAP  = (MAX_RIGHT < HW_SLOTS) ? MAX_RIGHT : HW_SLOTS;

  cmd_t    cmd;
  status_t status;
  idx_t    out_left;
  idx_t    out_right;
  logic    out_matched;
  logic    out_overflow;

  bam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bam_datapath #(
    .LEFT_CAP (LEFT_CAP),
    .COL_CAP  (COL_CAP)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .row_bits     (s_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_left     (out_left),
    .out_matched  (out_matched),
    .out_right    (out_right),
    .out_overflow (out_overflow),
    .out_last     (m_tlast)
  );

  // Pack the result word
  assign m_tdata = {out_right, out_left};
  assign m_tuser = {out_overflow, out_matched};

endmodule

`default_nettype wire

// File: rtl/bam_datapath.sv
// ---------------------------------------------------------------------------
// bam_datapath
// Row store, column ownership, search stack, column pick and result
// register of the bipartite matcher.
// ---------------------------------------------------------------------------
`default_nettype none

module bam_datapath
  import bam_pkg::*;
#(
  parameter int LEFT_CAP = 16,
  parameter int COL_CAP  = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire row_t    row_bits,
  input  wire cmd_t    cmd,
  output status_t      status,
  output logic         out_valid,
  input  wire logic    out_ready,
  output idx_t         out_left,
  output logic         out_matched,
  output idx_t         out_right,
  output logic         out_overflow,
  output logic         out_last
);

  // Payload storage
  row_t   adj [HW_SLOTS];
  idx_t   own_left [HW_SLOTS];
  idx_t   match_col [HW_SLOTS];
  frame_t stk [HW_SLOTS];

  // Control state
  logic [HW_SLOTS-1:0] own_valid;
  logic [HW_SLOTS-1:0] match_valid;
  row_t  visited;
  cnt_t  row_count;
  logic  dropped;
  idx_t  sp;
  idx_t  cur_left;
  cnt_t  cur_next;
  idx_t  idx;

  row_t   reach;
  row_t   cand_bits;
  idx_t   pick;
  frame_t top;

  // Columns still open to the current frame
  always_comb begin
    for (int b = 0; b < HW_SLOTS; b++) begin
      reach[b] = (CNT_W'(b) >= cur_next) && (b < COL_CAP);
    end
  end

  assign cand_bits = adj[cur_left] & ~visited & reach;

  // Lowest candidate column
  always_comb begin
    pick = '0;
    for (int b = HW_SLOTS - 1; b >= 0; b--) begin
      if (cand_bits[b]) begin
        pick = IDX_W'(b);
      end
    end
  end

  assign top = stk[sp - IDX_W'(1)];

  assign status.cand     = |cand_bits;
  assign status.col_free = !own_valid[pick];
  assign status.sp_zero  = (sp == '0);
  assign status.sp_one   = (sp == IDX_W'(1));
  assign status.idx_last = ({1'b0, idx} + CNT_W'(1)) == row_count;
  assign status.out_busy = out_valid && !out_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_valid   <= '0;
      match_valid <= '0;
      visited     <= '0;
      row_count   <= '0;
      dropped     <= 1'b0;
      sp          <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Store or drop an incoming row
      if (cmd.load_row) begin
        if (row_count < CNT_W'(LEFT_CAP)) begin
          row_count <= row_count + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.clear_set) begin
        own_valid   <= '0;
        match_valid <= '0;
      end
      if (cmd.clear_set || cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      // Walk the augmenting path
      if (cmd.start_aug) begin
        visited <= '0;
        sp      <= '0;
      end
      if (cmd.push) begin
        visited[pick] <= 1'b1;
        sp            <= sp + IDX_W'(1);
      end
      if (cmd.pop) begin
        sp <= sp - IDX_W'(1);
      end
      if (cmd.assign_col) begin
        visited[pick]         <= 1'b1;
        own_valid[pick]       <= 1'b1;
        match_valid[cur_left] <= 1'b1;
      end
      if (cmd.unwind) begin
        own_valid[top.col]    <= 1'b1;
        match_valid[top.left] <= 1'b1;
        sp                    <= sp - IDX_W'(1);
      end
      // Result register
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.end_set) begin
        row_count <= '0;
        dropped   <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_row && (row_count < CNT_W'(LEFT_CAP))) begin
      adj[row_count[IDX_W-1:0]] <= row_bits;
    end
    if (cmd.start_aug) begin
      cur_left <= idx;
      cur_next <= '0;
    end
    if (cmd.push) begin
      stk[sp]  <= '{left: cur_left, next: CNT_W'(pick) + CNT_W'(1), col: pick};
      cur_left <= own_left[pick];
      cur_next <= '0;
    end
    if (cmd.pop) begin
      cur_left <= top.left;
      cur_next <= top.next;
    end
    if (cmd.assign_col) begin
      own_left[pick]      <= cur_left;
      match_col[cur_left] <= pick;
    end
    if (cmd.unwind) begin
      own_left[top.col]   <= top.left;
      match_col[top.left] <= top.col;
    end
    if (cmd.emit) begin
      out_left     <= idx;
      out_matched  <= match_valid[idx];
      out_right    <= match_valid[idx] ? match_col[idx] : '0;
      out_overflow <= dropped;
      out_last     <= status.idx_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bam_ctrl.sv
// ---------------------------------------------------------------------------
// bam_ctrl
// Sequencer of the bipartite matcher: row load, one augmenting search per
// left row, path write-back and result emission.
// ---------------------------------------------------------------------------
`default_nettype none

module bam_ctrl
  import bam_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_last,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   aug_done;

  assign in_ready = (state == ST_LOAD);
  assign in_fire  = in_valid && in_ready;

  // Search for the current row ends on a free column at the root, a
  // finished write-back, or an exhausted root frame
  assign aug_done = ((state == ST_SEARCH) && status.sp_zero &&
                     (!status.cand || status.col_free)) ||
                    ((state == ST_UNWIND) && status.sp_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && in_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (aug_done) begin
          state_next = status.idx_last ? ST_EMIT : ST_START;
        end else if (status.cand && status.col_free) begin
          state_next = ST_UNWIND;
        end
      end
      ST_UNWIND: begin
        if (aug_done) begin
          state_next = status.idx_last ? ST_EMIT : ST_START;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy && status.idx_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_LOAD: begin
        cmd.load_row  = in_fire;
        cmd.clear_set = in_fire && in_last;
      end
      ST_START: begin
        cmd.start_aug = 1'b1;
      end
      ST_SEARCH: begin
        if (status.cand) begin
          cmd.assign_col = status.col_free;
          cmd.push       = !status.col_free;
        end else begin
          cmd.pop = !status.sp_zero;
        end
      end
      ST_UNWIND: begin
        cmd.unwind = 1'b1;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit    = 1'b1;
          cmd.end_set = status.idx_last;
          cmd.idx_inc = !status.idx_last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
    // Advance to the next row or rewind for emission
    if (aug_done) begin
      cmd.idx_inc   = !status.idx_last;
      cmd.idx_clear = status.idx_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bam_checker.sv
// ---------------------------------------------------------------------------
// bam_checker
// Port-level checks on the bipartite matcher, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bam_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  logic        m_fire_mid;
  logic [3:0]  m_left;
  logic [10:0] m_word;

  assign m_fire_mid = m_tvalid && m_tready && !m_tlast;
  assign m_left     = m_tdata[3:0];
  assign m_word     = {m_tlast, m_tuser, m_tdata};

  // Stalled word stays valid and unchanged
  `ASSERT_NEXT_CYCLE(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT_CYCLE(a_hold_word, m_tvalid && !m_tready, $stable(m_word))

  // No row is taken while a set is still being emitted
  `ASSERT_SAME_CYCLE(a_no_load_mid_set, m_tvalid && !m_tlast, !s_tready)

  // Results of one set follow back to back with rising left index
  `ASSERT_NEXT_CYCLE(a_index_step, m_fire_mid, m_tvalid && (m_left == $past(m_left) + 4'd1))

  // Overflow is the same on every word of a set
  `ASSERT_NEXT_CYCLE(a_overflow_steady, m_fire_mid, m_tuser[1] == $past(m_tuser[1]))

endmodule

bind bipartite_augmenting_matcher bam_checker u_bam_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: verif/tb_bipartite_augmenting_matcher.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bipartite_augmenting_matcher
// Streams adjacency matrices into the matcher and compares every result word
// with an in-bench maximum-matching predictor. The predictor runs the same
// ascending-column augmenting-path search. A short directed part covers
// full, empty, last-column, augmenting-chain and over-capacity sets. Random
// sets of mixed size and density follow, with bursty input and a stalling
// receiver.
// ---------------------------------------------------------------------------

module tb_bipartite_augmenting_matcher;
  import bam_pkg::*;

  localparam int unsigned RANDOM_ROWS = 384;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned SETTLE_CYCLES = 100;

  // One expected result word
  typedef struct {
    idx_t left;
    logic matched;
    idx_t right;
    logic overflow;
    logic last;
  } match_word_t;

  // Predicts the matching of each closed set and checks result words in order
  class kuhn_match_board;
    row_t         rows[HW_SLOTS];
    int unsigned  row_count;
    bit           dropped;
    bit           col_taken[HW_SLOTS];
    idx_t         col_owner[HW_SLOTS];
    match_word_t  expected_words[$];
    int unsigned  errors;
    int unsigned  rows_taken;
    int unsigned  sets_closed;
    int unsigned  overflow_sets;
    int unsigned  words_checked;
    int unsigned  words_matched;

    function new();
      row_count = 0;
      dropped = 1'b0;
      errors = 0;
      rows_taken = 0;
      sets_closed = 0;
      overflow_sets = 0;
      words_checked = 0;
      words_matched = 0;
    endfunction

    // Depth-first search for an augmenting path from one left row
    function void augment_from(int unsigned start);
      int unsigned frame_left[HW_SLOTS+1];
      int unsigned frame_next[HW_SLOTS+1];
      int unsigned frame_col[HW_SLOTS+1];
      int unsigned sp, col, u, k;
      row_t        seen;
      bit          pushed, done;
      sp = 0;
      seen = '0;
      frame_left[0] = start;
      frame_next[0] = 0;
      done = 1'b0;
      while (!done) begin
        u = frame_left[sp];
        pushed = 1'b0;
        col = frame_next[sp];
        while (col < HW_SLOTS && !pushed && !done) begin
          if (rows[u][col] && !seen[col]) begin
            seen[col] = 1'b1;
            if (!col_taken[col]) begin
              // free column: claim it and flip the path back to the root
              col_taken[col] = 1'b1;
              col_owner[col] = idx_t'(u);
              for (k = sp; k > 0; k--)
                col_owner[frame_col[k-1]] = idx_t'(frame_left[k-1]);
              done = 1'b1;
            end else begin
              // owned column: try to move its owner elsewhere
              frame_col[sp] = col;
              frame_next[sp] = col + 1;
              sp++;
              frame_left[sp] = col_owner[col];
              frame_next[sp] = 0;
              pushed = 1'b1;
            end
          end
          col++;
        end
        if (!pushed && !done) begin
          if (sp == 0) done = 1'b1;
          else sp--;
        end
      end
    endfunction

    // Note one accepted input word; a closing row queues the set's results
    function void take_row(row_t bits, logic closes);
      int unsigned i, j;
      bit          has_col[HW_SLOTS];
      idx_t        which_col[HW_SLOTS];
      match_word_t w;
      rows_taken++;
      if (row_count < HW_SLOTS) begin
        rows[row_count] = bits;
        row_count++;
      end else begin
        dropped = 1'b1;
      end
      if (closes) begin
        for (j = 0; j < HW_SLOTS; j++) begin
          col_taken[j] = 1'b0;
          col_owner[j] = '0;
          has_col[j] = 1'b0;
          which_col[j] = '0;
        end
        for (i = 0; i < row_count; i++)
          augment_from(i);
        for (j = 0; j < HW_SLOTS; j++) begin
          if (col_taken[j]) begin
            has_col[col_owner[j]] = 1'b1;
            which_col[col_owner[j]] = idx_t'(j);
          end
        end
        for (i = 0; i < row_count; i++) begin
          w.left = idx_t'(i);
          w.matched = has_col[i];
          w.right = has_col[i] ? which_col[i] : '0;
          w.overflow = dropped;
          w.last = (i + 1 == row_count);
          expected_words.insert(expected_words.size(), w);
        end
        sets_closed++;
        if (dropped) overflow_sets++;
        row_count = 0;
        dropped = 1'b0;
      end
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch on result word %0d: %s got %0d, expected %0d",
               words_checked, what, got, want);
    endtask

    // Compare one accepted result word with the oldest expectation
    task check_word(idx_t left, logic matched, idx_t right, logic overflow,
                    logic last);
      match_word_t w;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, left_index", left, 0);
      end else begin
        w = expected_words.pop_front();
        if (left !== w.left) report_mismatch("left_index", left, w.left);
        if (matched !== w.matched) report_mismatch("matched", matched, w.matched);
        if (right !== w.right) report_mismatch("right_index", right, w.right);
        if (overflow !== w.overflow) report_mismatch("overflow", overflow, w.overflow);
        if (last !== w.last) report_mismatch("last_result", last, w.last);
        if (w.matched) words_matched++;
      end
      words_checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] row_bits
  logic        s_tlast = 1'b0; // last_row
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [3:0] left_index, [7:4] right_index
  logic [1:0]  m_tuser;        // [0] matched, [1] overflow
  logic        m_tlast;        // last_result

  kuhn_match_board board;
  int unsigned     cycles = 0;
  int unsigned     rows_sent = 0;
  int unsigned     burst_left = 0;
  bit              steady = 1'b0;
  int unsigned     rx_left = 0;
  int unsigned     rx_mode = 0;
  logic [15:0]     rx_pattern = 16'hFFFF;

  bipartite_augmenting_matcher u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stall pattern: switch between always ready, a fixed bit
  // pattern and random stalls whenever the mode countdown runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_pattern <= 16'($urandom) | (16'h1 << $urandom_range(0, 15));
      rx_left <= $urandom_range(200, 600);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= rx_pattern[cycles[3:0]];
      default: m_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // Record accepted input words
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      board.take_row(s_tdata, s_tlast);
  end

  // Check accepted result words
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_word(m_tdata[3:0], m_tuser[0], m_tdata[7:4], m_tuser[1], m_tlast);
  end

  // Insert a random gap between bursts of input words
  task automatic pace_sender();
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!steady) gap = $urandom_range(0, 8);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one row and hold it until accepted
  task automatic send_row(input row_t bits, input logic closes);
    pace_sender();
    s_tvalid <= 1'b1;
    s_tdata <= bits;
    s_tlast <= closes;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rows_sent++;
  endtask

  // Hold off input until every expected word has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // One random set: half are sparse rows in a column window to force long
  // augmenting chains, the rest uniform or quarter-density, a few over capacity
  task automatic send_random_set();
    int unsigned size, style, base, span, nb, r;
    row_t        bits;
    size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    style = $urandom_range(0, 3);
    span = $urandom_range(1, 16);
    base = $urandom_range(0, 16 - span);
    steady = ($urandom_range(0, 4) == 0);
    for (r = 0; r < size; r++) begin
      case (style)
        0, 1: begin
          bits = '0;
          nb = $urandom_range(1, 3);
          repeat (nb) bits[base + $urandom_range(0, span - 1)] = 1'b1;
        end
        2: bits = row_t'($urandom);
        default: bits = row_t'($urandom) & row_t'($urandom);
      endcase
      if ($urandom_range(0, 15) == 0) bits = '0;
      send_row(bits, r == size - 1);
    end
  endtask

  initial begin
    int unsigned i, target;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: full row, empty row, top column only
    send_row(16'hFFFF, 1'b1);
    send_row(16'h0000, 1'b1);
    send_row(16'h8000, 1'b1);
    // Second row steals column 0, first row moves to column 1
    send_row(16'h0003, 1'b0);
    send_row(16'h0001, 1'b1);
    // Last row forces a three-deep chain of reassignments
    send_row(16'h0003, 1'b0);
    send_row(16'h0006, 1'b0);
    send_row(16'h000C, 1'b0);
    send_row(16'h0001, 1'b1);
    // Full capacity, then a dropped row that still closes the set
    for (i = 0; i < HW_SLOTS; i++)
      send_row(16'hFFFF, 1'b0);
    send_row(16'h5555, 1'b1);

    wait_drain();

    // Random sets, with an occasional full drain
    target = rows_sent + RANDOM_ROWS;
    while (rows_sent < target) begin
      send_random_set();
      if ($urandom_range(0, 9) == 0) wait_drain();
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d rows in %0d sets, %0d sets over capacity",
             board.rows_taken, board.sets_closed, board.overflow_sets);
    $display("checked %0d result words, %0d of them matched",
             board.words_checked, board.words_matched);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d words still pending",
               board.errors, board.outstanding());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
